/* hw/rtl/site_blocklist_substring_match_defines.svh */
// Assertion helpers used by the matcher RTL. All checks run on the rising edge of clock
// and are switched off while reset is high.
`ifndef SITE_BLOCKLIST_SUBSTRING_MATCH_DEFINES_SVH
`define SITE_BLOCKLIST_SUBSTRING_MATCH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBSM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBSM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/sbsm_pkg.sv */
package sbsm_pkg;

   localparam int ENTRIES_DEF   = 32;
   localparam int SITE_LEN_DEF  = 32;

   localparam int CHAR_W        = 8;
   localparam int LEVEL_W       = 2;
   localparam int ENTRY_FIELD_W = 5;
   localparam int POS_FIELD_W   = 5;
   localparam int LEN_FIELD_W   = 6;

   typedef logic [CHAR_W-1:0]  char_type;
   typedef logic [LEVEL_W-1:0] level_type;

   typedef enum logic [1:0] {
      KIND_PAT_CHAR  = 2'd0,
      KIND_PAT_SET   = 2'd1,
      KIND_HOST_CHAR = 2'd2,
      KIND_HOST_END  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_LAST
   } state_type;

   // Only the letters A through Z are folded; every other byte passes unchanged.
   function automatic char_type fold_lower(input char_type c);
      char_type r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5a) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

/* hw/rtl/sbsm_entry_update.sv */
module sbsm_entry_update
   import sbsm_pkg::*;
#(
   parameter int SITE_LEN = SITE_LEN_DEF,
   parameter int LEN_W    = $clog2(SITE_LEN + 1),
   parameter int POS_W    = (SITE_LEN > 1) ? $clog2(SITE_LEN) : 1
) (
   input  logic                        is_end,
   input  char_type                    host_char,
   input  logic [SITE_LEN-1:0][7:0]    row,
   input  logic [LEN_W-1:0]            len,
   input  level_type                   level,
   input  logic [SITE_LEN-1:0]         vec,
   input  logic                        matched,
   output logic [SITE_LEN-1:0]         vec_out,
   output logic                        matched_out,
   output level_type                   contrib
);

   logic [SITE_LEN-1:0] hits;
   logic [SITE_LEN-1:0] shifted;
   logic [SITE_LEN-1:0] new_vec;
   logic [LEN_W-1:0]    len_m1;
   logic                top_hit;

   always_comb begin
      for (int j = 0; j < SITE_LEN; j++) begin
         hits[j] = (row[j] == host_char) && (LEN_W'(j) < len);
      end
   end

   assign shifted = (vec << 1) | SITE_LEN'(1);
   assign new_vec = shifted & hits;
   assign len_m1  = len - LEN_W'(1);
   assign top_hit = new_vec[len_m1[POS_W-1:0]];

   always_comb begin
      if (is_end) begin
         // Hostname end drains the entry and clears its per-hostname state.
         vec_out     = '0;
         matched_out = 1'b0;
         contrib     = matched ? level : '0;
      end else if (len == '0) begin
         // An empty pattern matches as soon as the hostname has a byte.
         vec_out     = vec;
         matched_out = 1'b1;
         contrib     = '0;
      end else begin
         vec_out     = new_vec;
         matched_out = matched | top_hit;
         contrib     = '0;
      end
   end

endmodule

/* hw/rtl/site_blocklist_substring_match.sv */
// Multi-pattern substring matcher for hostnames.
// Items enter on the command port: an item is taken at a clock edge with start
// high and busy low. req_kind selects the operation: write one pattern byte,
// set an entry's length and level, feed one hostname byte, or end the hostname.
// Table writes finish at the accepting edge and keep busy low, so a new item
// can follow in the next cycle.
// A hostname byte or a hostname end walks the entry table through the entry
// memory, one entry a cycle, with a read-modify-write of each entry's match
// vector; the item holds busy high through ST_SCAN and ST_LAST after it is taken.
// Hostname end gives one result: rsp_valid pulses for one cycle with
// rsp_ban_level, the highest level among matched entries (0 if none), in the
// first cycle with busy low again.
// The receiver cannot stall; each result is shown for exactly one cycle.
// After reset the block clears the entry memory, one entry a cycle, and holds
// busy high in ST_CLEAR until the last entry is cleared. Pattern bytes are not
// cleared; a pattern byte that was never written reads as an arbitrary value.
`include "site_blocklist_substring_match_defines.svh"

module site_blocklist_substring_match
   import sbsm_pkg::*;
#(
   parameter int ENTRIES  = ENTRIES_DEF,
   parameter int SITE_LEN = SITE_LEN_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_kind,
   input  logic [ENTRY_FIELD_W-1:0] req_entry,
   input  logic [POS_FIELD_W-1:0]   req_position,
   input  logic [CHAR_W-1:0]        req_char_value,
   input  logic [LEN_FIELD_W-1:0]   req_pattern_length,
   input  logic [LEVEL_W-1:0]       req_level,
   output logic                     rsp_valid,
   output logic [LEVEL_W-1:0]       rsp_ban_level
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int POS_W = (SITE_LEN > 1) ? $clog2(SITE_LEN) : 1;
   localparam int LEN_W = $clog2(SITE_LEN + 1);
   localparam int EX_W  = (IDX_W > ENTRY_FIELD_W) ? IDX_W : ENTRY_FIELD_W;
   localparam int PX_W  = (POS_W > POS_FIELD_W) ? POS_W : POS_FIELD_W;
   localparam int LX_W  = (LEN_W > LEN_FIELD_W) ? LEN_W : LEN_FIELD_W;

   typedef struct packed {
      logic [LEN_W-1:0]    len;
      level_type           level;
      logic [SITE_LEN-1:0] vec;
      logic                matched;
   } entry_type;

   // Memories: pattern bytes by entry row, and per-entry match state.
   logic [SITE_LEN-1:0][7:0] chars_mem [ENTRIES];
   entry_type                ent_mem   [ENTRIES];
   logic [SITE_LEN-1:0][7:0] chars_rd_ff;
   entry_type                ent_rd_ff;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] s1_idx_ff;
   logic             s1_valid_ff, s1_valid_in;
   logic             is_end_ff, is_end_in;
   char_type         host_char_ff, host_char_in;
   level_type        best_ff, best_in;
   logic             rsp_valid_ff, rsp_valid_in;
   level_type        rsp_level_ff, rsp_level_in;

   kind_type         kind;
   logic             accept;
   logic             accept_scan;
   logic             last_idx;
   logic             clear_we;
   logic             scan_issue;
   logic             chr_we;
   logic             set_we;
   logic             entry_ok;
   logic             pos_ok;
   logic [EX_W-1:0]  entry_ext;
   logic [PX_W-1:0]  pos_ext;
   logic [LX_W-1:0]  plen_ext;
   logic [LX_W-1:0]  plen_sat;
   logic [IDX_W-1:0] wr_entry;
   logic [POS_W-1:0] wr_pos;
   logic [LEN_W-1:0] sat_len;

   logic [SITE_LEN-1:0] upd_vec;
   logic                upd_matched;
   level_type           upd_contrib;

   assign kind        = kind_type'(req_kind);
   assign accept      = start && !busy;
   assign accept_scan = accept && (kind == KIND_HOST_CHAR || kind == KIND_HOST_END);
   assign last_idx    = (idx_ff == IDX_W'(ENTRIES - 1));

   assign entry_ext = EX_W'(req_entry);
   assign pos_ext   = PX_W'(req_position);
   assign plen_ext  = LX_W'(req_pattern_length);
   assign wr_entry  = entry_ext[IDX_W-1:0];
   assign wr_pos    = pos_ext[POS_W-1:0];
   assign entry_ok  = (int'(req_entry) < ENTRIES);
   assign pos_ok    = (int'(req_position) < SITE_LEN);
   assign plen_sat  = (plen_ext > LX_W'(SITE_LEN)) ? LX_W'(SITE_LEN) : plen_ext;
   assign sat_len   = plen_sat[LEN_W-1:0];

   assign chr_we = accept && kind == KIND_PAT_CHAR && entry_ok && pos_ok;
   assign set_we = accept && kind == KIND_PAT_SET && entry_ok;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (last_idx) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept_scan) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (last_idx) state_in = ST_LAST;
         end
         ST_LAST: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      busy       = 1'b1;
      clear_we   = 1'b0;
      scan_issue = 1'b0;
      unique case (state_ff)
         ST_CLEAR: clear_we   = 1'b1;
         ST_IDLE:  busy       = 1'b0;
         ST_SCAN:  scan_issue = 1'b1;
         ST_LAST:  busy       = 1'b1;
         default:  busy       = 1'b1;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (accept_scan) begin
         idx_in = '0;
      end else if (clear_we || scan_issue) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   assign s1_valid_in  = scan_issue;
   assign is_end_in    = accept_scan ? (kind == KIND_HOST_END) : is_end_ff;
   assign host_char_in = accept_scan ? fold_lower(req_char_value) : host_char_ff;

   always_comb begin
      best_in = best_ff;
      if (accept_scan) begin
         best_in = '0;
      end else if (s1_valid_ff && upd_contrib > best_ff) begin
         best_in = upd_contrib;
      end
   end

   // The last entry's writeback happens in ST_LAST, so its level is already in best_in.
   assign rsp_valid_in = (state_ff == ST_LAST) && is_end_ff;
   assign rsp_level_in = best_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff    <= idx_ff;
      is_end_ff    <= is_end_in;
      host_char_ff <= host_char_in;
      best_ff      <= best_in;
      rsp_level_ff <= rsp_level_in;
   end

   always_ff @(posedge clock) begin
      if (chr_we) begin
         chars_mem[wr_entry][wr_pos] <= req_char_value;
      end
      chars_rd_ff <= chars_mem[idx_ff];
   end

   // Table writes, the clearing pass and scan writebacks never share a cycle,
   // and the scan touches each entry once, so no forwarding is needed.
   always_ff @(posedge clock) begin
      priority if (clear_we) begin
         ent_mem[idx_ff] <= '0;
      end else if (set_we) begin
         ent_mem[wr_entry].len   <= sat_len;
         ent_mem[wr_entry].level <= req_level;
      end else if (s1_valid_ff) begin
         ent_mem[s1_idx_ff].vec     <= upd_vec;
         ent_mem[s1_idx_ff].matched <= upd_matched;
      end
      ent_rd_ff <= ent_mem[idx_ff];
   end

   sbsm_entry_update #(
      .SITE_LEN (SITE_LEN),
      .LEN_W    (LEN_W),
      .POS_W    (POS_W)
   ) u_update (
      .is_end      (is_end_ff),
      .host_char   (host_char_ff),
      .row         (chars_rd_ff),
      .len         (ent_rd_ff.len),
      .level       (ent_rd_ff.level),
      .vec         (ent_rd_ff.vec),
      .matched     (ent_rd_ff.matched),
      .vec_out     (upd_vec),
      .matched_out (upd_matched),
      .contrib     (upd_contrib)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ban_level = rsp_level_ff;

   `SBSM_ASSERT_SAME(a_rsp_when_idle, rsp_valid, !busy, "result shown while block is busy")
   `SBSM_ASSERT_SAME(a_rsp_after_last, rsp_valid, $past(state_ff == ST_LAST), "result not after scan end")
   `SBSM_ASSERT_NEXT(a_end_holds_busy, accept && kind == KIND_HOST_END, busy, "hostname end did not start a scan")
   `SBSM_ASSERT_SAME(a_last_entry, state_ff == ST_LAST, s1_valid_ff && s1_idx_ff == IDX_W'(ENTRIES - 1), "scan did not end on the last entry")

endmodule
